// ----- rtl/mpeg_audio_header_frame_size_defines.svh -----
// Assertion macros for the MPEG audio header parser
`ifndef MPEG_AUDIO_HEADER_FRAME_SIZE_DEFINES_SVH
`define MPEG_AUDIO_HEADER_FRAME_SIZE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define MAHFS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define MAHFS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ----- rtl/mahfs_pkg.sv -----
package mahfs_pkg;

  localparam int NUM_STG   = 6;
  localparam int DIV_STG   = 4;
  localparam int DIV_STEPS = 3;
  localparam int QUO_W     = 12;
  localparam int REM_W     = 26;

  localparam logic [17:0] MUL_L1  = 18'd12000;
  localparam logic [17:0] MUL_L23 = 18'd144000;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [2:0] SYNC_HI    = 3'b111;
  localparam logic [1:0] VER_MPEG1  = 2'b11;
  localparam logic [1:0] VER_RSVD   = 2'b01;
  localparam logic [1:0] LAYER_RSVD = 2'b00;
  localparam logic [1:0] LAYER_I    = 2'b11;
  localparam logic [3:0] BIDX_BAD   = 4'hF;
  localparam logic [1:0] SIDX_BAD   = 2'b11;

  typedef struct packed {
    logic              ok;
    logic              layer_one;
    logic              pad;
    logic [8:0]        kbps;
    logic [15:0]       rate;
    logic [REM_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } pipe_t;

  typedef struct packed {
    logic [15:0] sample_rate_hz;
    logic [8:0]  bitrate_kbps;
    logic [11:0] frame_bytes;
    logic        header_valid;
  } result_t;

  // [lsf][layer index][bitrate index]
  localparam logic [8:0] KBPS_TBL [2][3][16] = '{
    '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    }
  };

  // [version code][sampling index]; version code 1 is reserved
  localparam logic [15:0] RATE_TBL [4][4] = '{
    '{16'd11025, 16'd12000, 16'd8000,  16'd0},
    '{16'd0,     16'd0,     16'd0,     16'd0},
    '{16'd22050, 16'd24000, 16'd16000, 16'd0},
    '{16'd44100, 16'd48000, 16'd32000, 16'd0}
  };

  function automatic logic [8:0] kbps_lookup(logic lsf, logic [1:0] lay, logic [3:0] bidx);
    logic [8:0] res;
    res = '0;
    if (lay != 2'd3) begin
      res = KBPS_TBL[lsf][lay][bidx];
    end
    return res;
  endfunction

endpackage

// ----- rtl/mpeg_audio_header_frame_size.sv -----
// MPEG-1/2/2.5 audio frame header parser. Each input word carries the first
// three header bytes (byte zero in bits 23:16) and yields one output word with
// the validity flag, the looked-up bitrate and sampling rate, and the frame
// length in bytes; an illegal header gives all zeros, free format gives the
// padding alone. One word is accepted every cycle while the output is not
// stalled. A result passes the decode, product and divider stages and the
// output register; the 12-bit restoring divider resolves three quotient bits
// per stage. Back-pressure stalls the occupied stages; no word is lost or repeated.
module mpeg_audio_header_frame_size
  import mahfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // header_bits[23:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // 2'b0, sample_rate_hz[15:0], bitrate_kbps[8:0]
                                  // then frame_bytes[11:0], header_valid
);

  logic [NUM_STG-1:0] vld_r, vld_nxt;
  logic [NUM_STG-1:0] adv;
  pipe_t              stg_r   [NUM_STG];
  pipe_t              stg_nxt [NUM_STG];
  logic               out_vld_r, out_vld_nxt;
  result_t            res_r, res_nxt;
  logic               adv_out;

  // decode, product and frame-length signals
  logic [7:0]  b0, b1, b2;
  logic        hdr_ok;
  logic [1:0]  lay;
  logic [26:0] prod;
  logic [11:0] quo_l1;

  always_comb begin
    adv_out = !out_vld_r || out_tready;
    adv[NUM_STG-1] = !vld_r[NUM_STG-1] || adv_out;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_tready = adv[0];

  always_comb begin
    b0 = in_tdata[23:16];
    b1 = in_tdata[15:8];
    b2 = in_tdata[7:0];
    hdr_ok = (b0 == SYNC_BYTE) && (b1[7:5] == SYNC_HI) && (b1[4:3] != VER_RSVD) &&
             (b1[2:1] != LAYER_RSVD) && (b2[7:4] != BIDX_BAD) && (b2[3:2] != SIDX_BAD);
    lay = 2'd3 - b1[2:1];

    stg_nxt[0].ok        = hdr_ok;
    stg_nxt[0].layer_one = (b1[2:1] == LAYER_I);
    stg_nxt[0].pad       = b2[1];
    stg_nxt[0].kbps      = hdr_ok ? kbps_lookup(b1[4:3] != VER_MPEG1, lay, b2[7:4]) : '0;
    stg_nxt[0].rate      = hdr_ok ? RATE_TBL[b1[4:3]][b2[3:2]] : '0;
    stg_nxt[0].rem       = '0;
    stg_nxt[0].quo       = '0;

    // numerator in bit/s times the layer factor
    stg_nxt[1] = stg_r[0];
    prod = {18'b0, stg_r[0].kbps} * {9'b0, (stg_r[0].layer_one ? MUL_L1 : MUL_L23)};
    stg_nxt[1].rem = prod[REM_W-1:0];
    stg_nxt[1].quo = '0;

    // restoring division, three quotient bits per stage
    for (int j = 0; j < DIV_STG; j++) begin
      stg_nxt[j+2] = stg_r[j+1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        if ({2'b0, stg_nxt[j+2].rem} >=
            (28'(stg_r[j+1].rate) << (QUO_W - 1 - DIV_STEPS * j - s))) begin
          stg_nxt[j+2].rem = stg_nxt[j+2].rem -
            REM_W'(28'(stg_r[j+1].rate) << (QUO_W - 1 - DIV_STEPS * j - s));
          stg_nxt[j+2].quo[QUO_W-1-DIV_STEPS*j-s] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    quo_l1 = {stg_r[NUM_STG-1].quo[9:0] + {9'b0, stg_r[NUM_STG-1].pad}, 2'b00};
    res_nxt.header_valid   = stg_r[NUM_STG-1].ok;
    res_nxt.bitrate_kbps   = stg_r[NUM_STG-1].kbps;
    res_nxt.sample_rate_hz = stg_r[NUM_STG-1].rate;
    if (!stg_r[NUM_STG-1].ok) begin
      res_nxt.frame_bytes = '0;
    end else if (stg_r[NUM_STG-1].layer_one) begin
      res_nxt.frame_bytes = quo_l1;
    end else begin
      res_nxt.frame_bytes = stg_r[NUM_STG-1].quo + {11'b0, stg_r[NUM_STG-1].pad};
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_tvalid;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
    out_vld_nxt = adv_out ? vld_r[NUM_STG-1] : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      vld_r     <= vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STG; k++) begin
      if (adv[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (adv_out) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, res_r};

`include "mpeg_audio_header_frame_size_defines.svh"

  `MAHFS_ASSERT_IMPLY(a_invalid_zero, out_tvalid && !res_r.header_valid,
    (res_r.frame_bytes == '0) && (res_r.bitrate_kbps == '0) && (res_r.sample_rate_hz == '0),
    "invalid header with non-zero result")
  `MAHFS_ASSERT_IMPLY(a_empty_ready, !out_vld_r, in_tready,
    "input stalled while output register empty")
  `MAHFS_ASSERT_IMPLY(a_frame_nonzero, out_tvalid && res_r.header_valid &&
    (res_r.bitrate_kbps != '0), res_r.frame_bytes != '0,
    "zero frame length for a coded bitrate")
  `MAHFS_ASSERT_NEVER(a_frame_range, out_tvalid && (res_r.frame_bytes > 12'd2881),
    "frame length out of range")

endmodule

// ----- sim/tb.sv -----
module tb;
  import mahfs_pkg::*;

  typedef struct packed {
    logic [23:0] hdr;
    logic        typed;
    result_t     want;
  } dir_row_t;

  localparam result_t NO_FRAME = '0;

  localparam dir_row_t DIRECTED [23] = '{
    '{24'h000000, 1'b1, NO_FRAME},
    '{24'hFFFFFF, 1'b1, NO_FRAME},
    '{24'hFEFB90, 1'b1, NO_FRAME},
    '{24'hFFDB90, 1'b1, NO_FRAME},
    '{24'hFFEB90, 1'b1, NO_FRAME},
    '{24'hFFF990, 1'b1, NO_FRAME},
    '{24'hFFFBF0, 1'b1, NO_FRAME},
    '{24'hFFFB9C, 1'b1, NO_FRAME},
    '{24'hFFFF02, 1'b1, '{16'd44100, 9'd0,   12'd4,    1'b1}},
    '{24'hFFE30A, 1'b1, '{16'd8000,  9'd0,   12'd1,    1'b1}},
    '{24'hFFFFEA, 1'b1, '{16'd32000, 9'd448, 12'd676,  1'b1}},
    '{24'hFFE3EB, 1'b1, '{16'd8000,  9'd160, 12'd2881, 1'b1}},
    '{24'hFFFB90, 1'b1, '{16'd44100, 9'd128, 12'd417,  1'b1}},
    '{24'hFFFDE4, 1'b1, '{16'd48000, 9'd384, 12'd1152, 1'b1}},
    '{24'hFFF714, 1'b0, NO_FRAME},
    '{24'hFFF5A6, 1'b0, NO_FRAME},
    '{24'hFFF3C8, 1'b0, NO_FRAME},
    '{24'hFFE752, 1'b0, NO_FRAME},
    '{24'hFFE584, 1'b0, NO_FRAME},
    '{24'hFFFD11, 1'b0, NO_FRAME},
    '{24'hFFFE76, 1'b0, NO_FRAME},
    '{24'hFFF2E0, 1'b0, NO_FRAME},
    '{24'hFFE1F3, 1'b0, NO_FRAME}
  };

  // [layer I, II, III][bitrate index]
  localparam int unsigned KBIT_V1 [3][15] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320}
  };
  localparam int unsigned KBIT_LSF [3][15] = '{
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
  };
  // [version code][sampling index]
  localparam int unsigned HZ [4][3] = '{
    '{11025, 12000, 8000},
    '{0, 0, 0},
    '{22050, 24000, 16000},
    '{44100, 48000, 32000}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;

  result_t frame_q [$];
  result_t got, want;
  bit      failed = 1'b0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;

  mpeg_audio_header_frame_size dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t frame_header_decode(logic [23:0] hdr);
    logic [7:0]  b1, b2;
    logic [1:0]  ver, lay_code, sidx, li;
    logic [3:0]  bidx;
    int unsigned kbit, hz, span;
    result_t     r;
    r = '0;
    b1 = hdr[15:8];
    b2 = hdr[7:0];
    ver = b1[4:3];
    lay_code = b1[2:1];
    bidx = b2[7:4];
    sidx = b2[3:2];
    if (hdr[23:16] != SYNC_BYTE || b1[7:5] != SYNC_HI || ver == VER_RSVD ||
        lay_code == LAYER_RSVD || bidx == BIDX_BAD || sidx == SIDX_BAD) begin
      return r;
    end
    li = 2'd3 - lay_code;
    kbit = (ver == VER_MPEG1) ? KBIT_V1[li][bidx] : KBIT_LSF[li][bidx];
    hz = HZ[ver][sidx];
    if (lay_code == LAYER_I) begin
      span = ((12 * kbit * 1000) / hz + b2[1]) * 4;
    end else begin
      span = (144 * kbit * 1000) / hz + b2[1];
    end
    r.header_valid = 1'b1;
    r.frame_bytes = span[11:0];
    r.bitrate_kbps = kbit[8:0];
    r.sample_rate_hz = hz[15:0];
    return r;
  endfunction

  task automatic send_word(input logic [23:0] hdr, input logic typed, input result_t exp_r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= hdr;
    do @(posedge clk); while (!in_tready);
    frame_q.push_back(typed ? exp_r : frame_header_decode(hdr));
  endtask

  task automatic drain_frames();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (frame_q.size() != 0) @(negedge clk);
  endtask

  // receiver side; a hold-off request blocks it for a long stretch
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 150;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[37:0];
      if (frame_q.size() == 0) begin
        $display("%0t: word with nothing expected: %h", $time, out_tdata);
        failed = 1'b1;
      end else begin
        want = frame_q.pop_front();
        if (got.header_valid !== want.header_valid || got.frame_bytes !== want.frame_bytes ||
            got.bitrate_kbps !== want.bitrate_kbps ||
            got.sample_rate_hz !== want.sample_rate_hz) begin
          $display("%0t: mismatch exp valid=%0d bytes=%0d kbps=%0d hz=%0d", $time,
                   want.header_valid, want.frame_bytes, want.bitrate_kbps,
                   want.sample_rate_hz);
          $display("%0t:          got valid=%0d bytes=%0d kbps=%0d hz=%0d", $time,
                   got.header_valid, got.frame_bytes, got.bitrate_kbps,
                   got.sample_rate_hz);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    logic [23:0] hdr;
    int          pick;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_word(DIRECTED[i].hdr, DIRECTED[i].typed, DIRECTED[i].want);
    end
    drain_frames();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int i = 0; i < 350; i++) begin
        if (ph == 0 && i == 100) hold_req = 1'b1;
        if (ph == 2 && i == 175) drain_frames();
        pick = $urandom_range(99);
        if (pick < 80) begin
          hdr = {SYNC_BYTE, SYNC_HI, 5'($urandom_range(31)), 8'($urandom_range(255))};
        end else if (pick < 90) begin
          // one sync bit broken
          hdr = {SYNC_BYTE, SYNC_HI, 5'($urandom_range(31)), 8'($urandom_range(255))};
          hdr[13 + $urandom_range(10)] ^= 1'b1;
        end else begin
          hdr = 24'($urandom);
        end
        send_word(hdr, 1'b0, NO_FRAME);
      end
    end

    drain_frames();
    repeat (20) @(negedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- mpeg_audio_header_frame_size.f -----
+incdir+rtl
rtl/mahfs_pkg.sv
rtl/mpeg_audio_header_frame_size.sv
sim/tb.sv
